// ===== sv/smir_pkg.sv =====
`timescale 1ns / 1ps
package smir_pkg;
   localparam int NUM_SEGS_DEF  = 256;
   localparam int SEG_WORDS_DEF = 1024;

   localparam logic [2:0] MODE_MAP    = 3'd0;
   localparam logic [2:0] MODE_UNMAP  = 3'd1;
   localparam logic [2:0] MODE_LOAD   = 3'd2;
   localparam logic [2:0] MODE_STORE  = 3'd3;
   localparam logic [2:0] MODE_COPY   = 3'd4;
   localparam logic [2:0] MODE_APPEND = 3'd5;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NO_ID   = 3'd1;
   localparam logic [2:0] ST_BAD_SEG = 3'd2;
   localparam logic [2:0] ST_BAD_OFF = 3'd3;
   localparam logic [2:0] ST_TOO_BIG = 3'd4;

   typedef struct packed {
      logic [7:0]  new_id;
      logic [31:0] read_word;
      logic [2:0]  status;
   } rsp_type;
endpackage

// ===== sv/smir_word_ram.sv =====
`timescale 1ns / 1ps
module smir_word_ram #(
   parameter int DEPTH = 262144,
   parameter int AW    = 18
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);
   logic [31:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== sv/segmented_memory_with_id_recycling_unit.sv =====
`timescale 1ns / 1ps
// Flow: each request passes S_LOOK then S_OUT; load also passes S_LDW, a successful map
// writes one zero word per cycle in S_FILL, and copy alternates S_CRD reads and S_CWR
// writes per word (segment 0 as source is a no-op).
// Throughput: one item at a time; with rsp_ready high the next word can be taken
// in the cycle after the result.
// Reset: synchronous; segment 0 mapped and empty, id counter at one, free stack
// empty. Word memory and free stack contents are not cleared.
module segmented_memory_with_id_recycling_unit
   import smir_pkg::*;
#(
   parameter int NUM_SEGS  = NUM_SEGS_DEF,
   parameter int SEG_WORDS = SEG_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [7:0]  req_seg_id,
   input  logic [9:0]  req_offset,
   input  logic [31:0] req_data_word,
   input  logic [10:0] req_num_words,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_new_id,
   output logic [31:0] rsp_read_word,
   output logic [2:0]  rsp_status
);
   localparam int SW = (NUM_SEGS > 1) ? $clog2(NUM_SEGS) : 1;
   localparam int OW = (SEG_WORDS > 1) ? $clog2(SEG_WORDS) : 1;
   localparam int LW = $clog2(SEG_WORDS + 1);
   localparam int CW = $clog2(NUM_SEGS + 1);
   localparam int AW = SW + OW;

   typedef enum logic [2:0] {S_IDLE, S_LOOK, S_FILL, S_CRD, S_CWR, S_LDW, S_OUT}
      state_type;

   state_type state_ff;
   logic [2:0]  mode_ff;
   logic [7:0]  seg_ff;
   logic [9:0]  off_ff;
   logic [31:0] data_ff;
   logic [10:0] nw_ff;
   logic [CW-1:0] freed_count_ff;
   logic [CW-1:0] fresh_id_ff;
   logic [LW-1:0] len0_ff;
   logic [LW-1:0] idx_ff, cnt_ff;
   logic [SW-1:0] id_ff;
   rsp_type rsp_ff;

   // per-segment length table and free stack: synchronous RAMs; mapped bits in flops
   logic [LW-1:0] len_mem [NUM_SEGS];
   logic [SW-1:0] stack_mem [NUM_SEGS];
   logic [NUM_SEGS-1:0] mapped_ff;
   logic [LW-1:0] len_rd_ff;
   logic [SW-1:0] stack_rd_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0]   wr_data, rd_data;

   logic          st_en;
   logic [AW-1:0] st_addr;

   logic seg_ok;
   logic [SW-1:0] seg_idx;
   logic [SW-1:0] len_rd_idx;
   assign seg_idx = SW'(seg_ff);
   // length lookup starts at the accept edge so it is ready in S_LOOK
   assign len_rd_idx = (state_ff == S_IDLE) ? SW'(req_seg_id) : seg_idx;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_new_id = rsp_ff.new_id;
   assign rsp_read_word = rsp_ff.read_word;
   assign rsp_status = rsp_ff.status;

   smir_word_ram #(.DEPTH(NUM_SEGS * SEG_WORDS), .AW(AW)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   logic [CW-1:0] pop_idx;
   assign pop_idx = freed_count_ff - CW'(1);

   always_ff @(posedge clock) begin
      len_rd_ff   <= len_mem[len_rd_idx];
      stack_rd_ff <= stack_mem[pop_idx[SW-1:0]];
   end

   always_comb begin
      wr_en = 1'b0;
      wr_addr = {id_ff, OW'(idx_ff)};
      wr_data = 32'd0;
      rd_addr = {seg_idx, off_ff[OW-1:0]};
      case (state_ff)
         S_LOOK: begin
            wr_en = st_en;
            wr_addr = st_addr;
            wr_data = data_ff;
         end
         S_FILL: wr_en = (idx_ff < LW'(nw_ff));
         S_CRD: rd_addr = {seg_idx, OW'(idx_ff)};
         S_CWR: begin
            wr_en = 1'b1;
            wr_addr = {SW'(0), OW'(cnt_ff)};
            wr_data = rd_data;
            rd_addr = {seg_idx, OW'(idx_ff)};
         end
         default: ;
      endcase
   end

   logic seg_len_zero_ok;
   always_comb begin
      seg_ok = mapped_ff[seg_idx] && ({24'd0, seg_ff} < 32'(NUM_SEGS));
      seg_len_zero_ok = (seg_idx == SW'(0)) ? 1'b1 : 1'b0;
   end

   logic [LW-1:0] slen;
   assign slen = (seg_idx == SW'(0)) ? len0_ff : len_rd_ff;

   // stores and appends go through the word RAM write port in S_LOOK
   always_comb begin
      st_en = 1'b0;
      st_addr = {seg_idx, off_ff[OW-1:0]};
      if (state_ff == S_LOOK) begin
         if (mode_ff == MODE_STORE && seg_ok && LW'(off_ff) < slen) st_en = 1'b1;
         if (mode_ff == MODE_APPEND && len0_ff < LW'(SEG_WORDS)) begin
            st_en = 1'b1;
            st_addr = {SW'(0), OW'(len0_ff)};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         freed_count_ff <= '0;
         fresh_id_ff <= CW'(1);
         len0_ff <= '0;
         mapped_ff <= NUM_SEGS'(1);
      end else begin
         case (state_ff)
            S_IDLE: if (req_valid) begin
               mode_ff <= req_mode; seg_ff <= req_seg_id;
               off_ff <= req_offset; data_ff <= req_data_word; nw_ff <= req_num_words;
               rsp_ff <= '0;
               state_ff <= S_LOOK;
            end
            S_LOOK: begin
               state_ff <= S_OUT;
               case (mode_ff)
                  MODE_MAP: begin
                     if (nw_ff > 11'(SEG_WORDS)) rsp_ff.status <= ST_TOO_BIG;
                     else if (freed_count_ff == '0 && fresh_id_ff >= CW'(NUM_SEGS))
                        rsp_ff.status <= ST_NO_ID;
                     else begin
                        if (freed_count_ff != '0) begin
                           freed_count_ff <= pop_idx; id_ff <= stack_rd_ff;
                           rsp_ff.new_id <= 8'(stack_rd_ff);
                        end else begin
                           fresh_id_ff <= fresh_id_ff + CW'(1);
                           id_ff <= SW'(fresh_id_ff);
                           rsp_ff.new_id <= 8'(fresh_id_ff);
                        end
                        idx_ff <= '0;
                        state_ff <= S_FILL;
                     end
                  end
                  MODE_UNMAP: begin
                     if (seg_len_zero_ok || !seg_ok) rsp_ff.status <= ST_BAD_SEG;
                     else begin
                        mapped_ff[seg_idx] <= 1'b0;
                        len_mem[seg_idx] <= '0;
                        if (freed_count_ff < CW'(NUM_SEGS)) begin
                           stack_mem[freed_count_ff[SW-1:0]] <= seg_idx;
                           freed_count_ff <= freed_count_ff + CW'(1);
                        end
                     end
                  end
                  MODE_LOAD, MODE_STORE: begin
                     if (!seg_ok) rsp_ff.status <= ST_BAD_SEG;
                     else if (LW'(off_ff) >= slen) rsp_ff.status <= ST_BAD_OFF;
                     else if (mode_ff == MODE_LOAD) state_ff <= S_LDW;
                  end
                  MODE_COPY: begin
                     if (!seg_ok) rsp_ff.status <= ST_BAD_SEG;
                     else if (!seg_len_zero_ok) begin
                        idx_ff <= '0; cnt_ff <= '0; nw_ff <= 11'(len_rd_ff);
                        state_ff <= S_CRD;
                     end
                  end
                  MODE_APPEND: begin
                     if (len0_ff >= LW'(SEG_WORDS)) rsp_ff.status <= ST_TOO_BIG;
                     else len0_ff <= len0_ff + LW'(1);
                  end
                  default: ;
               endcase
            end
            S_LDW: begin
               rsp_ff.read_word <= rd_data;
               state_ff <= S_OUT;
            end
            S_FILL: begin
               if (idx_ff >= LW'(nw_ff)) begin
                  len_mem[id_ff] <= LW'(nw_ff);
                  mapped_ff[id_ff] <= 1'b1;
                  state_ff <= S_OUT;
               end else idx_ff <= idx_ff + LW'(1);
            end
            S_CRD: begin
               if (idx_ff >= LW'(nw_ff)) begin
                  len0_ff <= LW'(nw_ff);
                  state_ff <= S_OUT;
               end else begin
                  idx_ff <= idx_ff + LW'(1);
                  state_ff <= S_CWR;
               end
            end
            S_CWR: begin
               cnt_ff <= cnt_ff + LW'(1);
               state_ff <= S_CRD;
            end
            S_OUT: if (rsp_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("accept while result pending");
   a_fresh: assert property (@(posedge clock) disable iff (reset)
      fresh_id_ff <= CW'(NUM_SEGS)) else $error("fresh id overran");
   a_seg0: assert property (@(posedge clock) disable iff (reset)
      mapped_ff[0]) else $error("segment zero unmapped");
endmodule

// ===== bench/tb_segmented_memory_with_id_recycling_unit.sv =====
`timescale 1ns / 1ps
module tb_segmented_memory_with_id_recycling_unit;
   import smir_pkg::*;

   localparam int NSEG  = NUM_SEGS_DEF;
   localparam int NWORD = SEG_WORDS_DEF;

   class seg_mem_scoreboard;
      bit [31:0] words [int];
      int unsigned seg_len [NSEG];
      bit          seg_live [NSEG];
      int unsigned free_ids [$];
      int unsigned next_fresh;
      rsp_type     pending [$];
      int          checked;

      function void clear();
         words.delete();
         foreach (seg_len[i]) begin
            seg_len[i] = 0;
            seg_live[i] = 0;
         end
         seg_live[0] = 1;
         free_ids.delete();
         next_fresh = 1;
         pending.delete();
      endfunction

      function void note_word(bit [2:0] mode, bit [7:0] seg, bit [9:0] off,
                              bit [31:0] data, bit [10:0] nw);
         rsp_type r;
         int unsigned id;
         int unsigned len;
         r = '0;
         case (mode)
            MODE_MAP: begin
               if (nw > NWORD) r.status = ST_TOO_BIG;
               else if (free_ids.size() == 0 && next_fresh >= NSEG) r.status = ST_NO_ID;
               else begin
                  if (free_ids.size() > 0) id = free_ids.pop_back();
                  else begin
                     id = next_fresh;
                     next_fresh++;
                  end
                  for (int i = 0; i < nw; i++) words[id * NWORD + i] = '0;
                  seg_len[id] = nw;
                  seg_live[id] = 1;
                  r.new_id = id[7:0];
               end
            end
            MODE_UNMAP: begin
               if (seg == 0 || !seg_live[seg]) r.status = ST_BAD_SEG;
               else begin
                  seg_live[seg] = 0;
                  seg_len[seg] = 0;
                  if (free_ids.size() < NSEG) free_ids.push_back(seg);
               end
            end
            MODE_LOAD, MODE_STORE: begin
               if (!seg_live[seg]) r.status = ST_BAD_SEG;
               else if (off >= seg_len[seg]) r.status = ST_BAD_OFF;
               else if (mode == MODE_LOAD) r.read_word = words[seg * NWORD + off];
               else words[seg * NWORD + off] = data;
            end
            MODE_COPY: begin
               if (!seg_live[seg]) r.status = ST_BAD_SEG;
               else if (seg != 0) begin
                  len = seg_len[seg];
                  for (int i = 0; i < len; i++) words[i] = words[seg * NWORD + i];
                  seg_len[0] = len;
               end
            end
            MODE_APPEND: begin
               len = seg_len[0];
               if (len >= NWORD) r.status = ST_TOO_BIG;
               else begin
                  words[len] = data;
                  seg_len[0] = len + 1;
               end
            end
            default: ;
         endcase
         pending.push_back(r);
      endfunction

      function bit check_word(rsp_type got, output string why);
         rsp_type exp_r;
         why = "";
         if (pending.size() == 0) begin
            why = $sformatf("unexpected word id=%0d rd=%h st=%0d",
                            got.new_id, got.read_word, got.status);
            return 0;
         end
         exp_r = pending.pop_front();
         checked++;
         if (got.new_id != exp_r.new_id)
            why = $sformatf("new_id got %0d want %0d", got.new_id, exp_r.new_id);
         else if (got.read_word != exp_r.read_word)
            why = $sformatf("read_word got %h want %h", got.read_word, exp_r.read_word);
         else if (got.status != exp_r.status)
            why = $sformatf("status got %0d want %0d", got.status, exp_r.status);
         return why == "";
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [2:0]  req_mode = '0;
   logic [7:0]  req_seg_id = '0;
   logic [9:0]  req_offset = '0;
   logic [31:0] req_data_word = '0;
   logic [10:0] req_num_words = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [7:0]  rsp_new_id;
   logic [31:0] rsp_read_word;
   logic [2:0]  rsp_status;

   seg_mem_scoreboard mem_sb;
   int  fail_count = 0;
   int  sent = 0;
   bit  calm = 0;
   bit  stop_drain = 0;
   bit  hold_go = 0;
   int  hold_cnt = 0;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   segmented_memory_with_id_recycling_unit uut (.*);

   task automatic report(input string msg);
      $display("mismatch @%0t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic send_word(input logic [2:0] mode, input logic [7:0] seg,
                            input logic [9:0] off, input logic [31:0] data,
                            input logic [10:0] nw);
      req_valid <= 1;
      req_mode <= mode;
      req_seg_id <= seg;
      req_offset <= off;
      req_data_word <= data;
      req_num_words <= nw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      mem_sb.note_word(mode, seg, off, data, nw);
      sent++;
      // idle gap after the accept; otherwise the next word follows at once
      if (!calm && $urandom_range(99) < 23) begin
         req_valid <= 0;
         @(posedge clock);
         while (!calm && $urandom_range(99) < 23) @(posedge clock);
      end
   endtask

   // live id list tracks the model so most accesses hit mapped segments
   function automatic logic [7:0] pick_seg();
      int k;
      if ($urandom_range(9) == 0) return 8'($urandom_range(255));
      k = $urandom_range(mem_sb.next_fresh > 1 ? mem_sb.next_fresh - 1 : 0);
      if (mem_sb.seg_live[k]) return 8'(k);
      return 8'd0;
   endfunction

   function automatic logic [9:0] pick_off(input logic [7:0] seg);
      int unsigned len;
      len = mem_sb.seg_len[seg];
      if (len == 0 || $urandom_range(9) == 0) return 10'($urandom_range(1023));
      return 10'($urandom_range(len - 1));
   endfunction

   // receiver
   always @(posedge clock) begin
      rsp_type got;
      string why;
      if (!reset && rsp_valid && rsp_ready) begin
         got.new_id = rsp_new_id;
         got.read_word = rsp_read_word;
         got.status = rsp_status;
         if (!mem_sb.check_word(got, why)) report(why);
      end
      if (hold_go && hold_cnt < 300) begin
         rsp_ready <= 0;
         hold_cnt <= hold_cnt + 1;
      end else begin
         rsp_ready <= calm || stop_drain || ($urandom_range(99) >= 23);
      end
   end

   initial begin
      #50000000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int n;
      logic [2:0] m;
      logic [7:0] s;
      logic [10:0] nw;
      mem_sb = new();
      mem_sb.clear();
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed
      send_word(MODE_LOAD, 8'd0, 10'd0, '0, '0);
      send_word(MODE_UNMAP, 8'd0, '0, '0, '0);
      send_word(MODE_UNMAP, 8'd255, '0, '0, '0);
      send_word(MODE_COPY, 8'd0, '0, '0, '0);
      send_word(MODE_APPEND, '0, '0, 32'hFFFF_FFFF, '0);
      send_word(MODE_APPEND, '0, '0, 32'h0, '0);
      send_word(MODE_LOAD, 8'd0, 10'd0, '0, '0);
      send_word(MODE_MAP, '0, '0, '0, 11'd1025);
      send_word(MODE_MAP, '0, '0, '0, 11'd2047);
      send_word(MODE_MAP, '0, '0, '0, 11'd0);
      send_word(MODE_LOAD, 8'd1, 10'd0, '0, '0);
      send_word(MODE_MAP, '0, '0, '0, 11'd1024);
      send_word(MODE_STORE, 8'd2, 10'd1023, 32'hDEAD_BEEF, '0);
      send_word(MODE_LOAD, 8'd2, 10'd1023, '0, '0);
      send_word(MODE_LOAD, 8'd2, 10'd0, '0, '0);
      send_word(MODE_COPY, 8'd2, '0, '0, '0);
      send_word(MODE_APPEND, '0, '0, 32'h1234_5678, '0);
      send_word(MODE_LOAD, 8'd0, 10'd1023, '0, '0);
      send_word(MODE_UNMAP, 8'd1, '0, '0, '0);
      send_word(MODE_UNMAP, 8'd1, '0, '0, '0);
      send_word(MODE_MAP, '0, '0, '0, 11'd3);
      send_word(3'd6, 8'hFF, 10'h3FF, 32'hFFFF_FFFF, 11'h7FF);
      send_word(3'd7, '0, '0, '0, '0);
      send_word(MODE_STORE, 8'd9, 10'd0, 32'h5, '0);

      // long receiver hold while the sender keeps offering appends
      hold_go = 1;
      for (int i = 0; i < 40; i++) send_word(MODE_APPEND, '0, '0, $urandom, '0);

      for (int i = 0; i < 1000; i++) begin
         calm = (i >= 400 && i < 550);
         n = $urandom_range(99);
         if (n < 12) begin
            // mostly small maps; some are oversized
            nw = ($urandom_range(19) == 0) ? 11'($urandom_range(2047))
                                           : 11'($urandom_range(12));
            send_word(MODE_MAP, 8'($urandom), 10'($urandom), $urandom, nw);
         end else if (n < 20) begin
            send_word(MODE_UNMAP, pick_seg(), 10'($urandom), $urandom, 11'($urandom));
         end else if (n < 50) begin
            s = pick_seg();
            send_word(MODE_STORE, s, pick_off(s), $urandom, 11'($urandom));
         end else if (n < 80) begin
            s = pick_seg();
            send_word(MODE_LOAD, s, pick_off(s), $urandom, 11'($urandom));
         end else if (n < 84) begin
            send_word(MODE_COPY, pick_seg(), 10'($urandom), $urandom, 11'($urandom));
         end else if (n < 97) begin
            send_word(MODE_APPEND, 8'($urandom), 10'($urandom), $urandom,
                      11'($urandom));
         end else begin
            m = 3'($urandom_range(6, 7));
            send_word(m, 8'($urandom), 10'($urandom), $urandom, 11'($urandom));
         end
      end
      calm = 0;
      req_valid <= 0;
      stop_drain = 1;
      while (mem_sb.pending.size() != 0) @(posedge clock);
      repeat (2100) @(posedge clock);
      $display("covered %0d commands, %0d results checked, %0d ids handed out fresh",
               sent, mem_sb.checked, mem_sb.next_fresh - 1);
      if (fail_count == 0 && mem_sb.pending.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
